// ===== hdl/session_id_bitmap_allocator_assert.svh =====
// Assertion macros for the session ID allocator checker.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef SESSION_ID_BITMAP_ALLOCATOR_ASSERT_SVH
`define SESSION_ID_BITMAP_ALLOCATOR_ASSERT_SVH

// immediate-implication check, clocked, disabled in reset
`define SIDA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// next-cycle implication check
`define SIDA_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== hdl/sida_pkg.sv =====
// Package for the session ID allocator: sizes, request and status codes,
// and the token that walks the cell chain. No dependencies.
package sida_pkg;

  localparam int NUM_SESSIONS = 1024;
  localparam int CELL_W       = 32;
  localparam int BIT_W        = $clog2(CELL_W);
  localparam int NUM_CELLS    = (NUM_SESSIONS + CELL_W - 1) / CELL_W;
  localparam int CIDX_W       = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
  localparam int SID_W        = 16;
  localparam int GID_W        = 10;

  typedef enum logic [1:0] {
    REQ_ALLOC  = 2'd0,
    REQ_FREE   = 2'd1,
    REQ_LOOKUP = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_RANGE     = 3'd2,
    ST_RESERVED  = 3'd3,
    ST_WAS_FREE  = 3'd4,
    ST_NOT_ALLOC = 3'd5
  } status_e;

  typedef struct packed {
    logic              valid;
    logic              done;
    logic [1:0]        op;
    logic [CIDX_W-1:0] sid_word;
    logic [BIT_W-1:0]  sid_bit;
    status_e           status;
    logic [GID_W-1:0]  gid;
    logic              found;
  } token_t;

endpackage

// ===== hdl/session_id_bitmap_allocator.sv =====
// Top level of the session ID allocator: request decode, the chain of
// bitmap cells and the result register. Depends on sida_pkg, sida_cell.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------
//  request  | start, busy        | req_type_i, session_id_i
//  result   | done_o (strobe)    | status_o, granted_id_o, found_o
//
// A request is decoded into the input token register, passes through the
// register of each cell as the token walks the chain, then the result
// register. busy is high from the accepted beat until the result strobe,
// so a new beat may start in the strobe cycle. Reset clears the whole
// bitmap at once. The result strobe lasts one cycle and cannot be stalled.
module session_id_bitmap_allocator (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 req_type_i,
  input  logic [sida_pkg::SID_W-1:0] session_id_i,
  output logic                       done_o,
  output logic [2:0]                 status_o,
  output logic [sida_pkg::GID_W-1:0] granted_id_o,
  output logic                       found_o
);
  import sida_pkg::*;

  token_t tok_w [NUM_CELLS+1];
  token_t tok_in_q, tok_in_d;
  token_t last;
  logic   accept;
  logic   in_range;
  logic   busy_q, busy_d;
  logic   done_q;
  status_e          status_q, status_d;
  logic [GID_W-1:0] gid_q, gid_d;
  logic             found_q, found_d;

  assign accept   = start && !busy_q;
  assign in_range = 32'(session_id_i) < NUM_SESSIONS;

  always_comb begin
    tok_in_d          = '0;
    tok_in_d.valid    = accept;
    tok_in_d.op       = req_type_i;
    tok_in_d.sid_word = session_id_i[CIDX_W+BIT_W-1:BIT_W];
    tok_in_d.sid_bit  = session_id_i[BIT_W-1:0];
    tok_in_d.status   = ST_OK;
    case (req_type_i)
      REQ_ALLOC: ;
      REQ_FREE: begin
        if (!in_range) begin
          tok_in_d.done   = 1'b1;
          tok_in_d.status = ST_RANGE;
        end else if (session_id_i == '0) begin
          tok_in_d.done   = 1'b1;
          tok_in_d.status = ST_RESERVED;
        end
      end
      REQ_LOOKUP: begin
        if (!in_range) begin
          tok_in_d.done   = 1'b1;
          tok_in_d.status = ST_RANGE;
        end
      end
      default: tok_in_d.done = 1'b1;
    endcase
  end

  assign tok_w[0] = tok_in_q;

  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    sida_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (CIDX_W'(g)),
      .tok_i      (tok_w[g]),
      .tok_o      (tok_w[g+1])
    );
  end

  assign last = tok_w[NUM_CELLS];

  always_comb begin
    busy_d = busy_q;
    if (accept) begin
      busy_d = 1'b1;
    end else if (last.valid) begin
      busy_d = 1'b0;
    end
    status_d = last.status;
    gid_d    = last.gid;
    found_d  = last.found;
    if (!last.done) begin
      status_d = ST_FULL;
      gid_d    = '0;
      found_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_in_q <= '0;
      busy_q   <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      tok_in_q <= tok_in_d;
      busy_q   <= busy_d;
      done_q   <= last.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (last.valid) begin
      status_q <= status_d;
      gid_q    <= gid_d;
      found_q  <= found_d;
    end
  end

  assign busy         = busy_q;
  assign done_o       = done_q;
  assign status_o     = status_q;
  assign granted_id_o = gid_q;
  assign found_o      = found_q;

endmodule

// ===== hdl/sida_cell.sv =====
// One cell of the allocator chain: holds CELL_W allocation bits and
// serves the request token passing through. Depends on sida_pkg.
module sida_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [sida_pkg::CIDX_W-1:0] cell_idx_i,
  input  sida_pkg::token_t            tok_i,
  output sida_pkg::token_t            tok_o
);
  import sida_pkg::*;

  logic [CELL_W-1:0] bits_q, bits_d;
  logic [CELL_W-1:0] usable, free_vec, iso;
  logic [BIT_W-1:0]  ffz;
  logic [CIDX_W+BIT_W-1:0] gidx;
  logic [31:0]       gid_full;
  logic              hit;
  logic              bit_set;
  token_t            tok_q, tok_d;

  always_comb begin
    for (int b = 0; b < CELL_W; b++) begin
      usable[b] = (32'({cell_idx_i, BIT_W'(b)}) != 32'd0) &&
                  (32'({cell_idx_i, BIT_W'(b)}) < NUM_SESSIONS);
    end
    free_vec = ~bits_q & usable;
    iso      = free_vec & (~free_vec + 1'b1);
    ffz      = '0;
    for (int b = 0; b < CELL_W; b++) begin
      if (iso[b]) begin
        ffz = ffz | BIT_W'(b);
      end
    end
    gidx     = {cell_idx_i, ffz};
    gid_full = 32'(gidx);
    hit      = (tok_i.sid_word == cell_idx_i);
    bit_set  = bits_q[tok_i.sid_bit];

    tok_d  = tok_i;
    bits_d = bits_q;
    if (tok_i.valid && !tok_i.done) begin
      case (tok_i.op)
        REQ_ALLOC: begin
          if (|free_vec) begin
            bits_d       = bits_q | iso;
            tok_d.done   = 1'b1;
            tok_d.status = ST_OK;
            tok_d.gid    = gid_full[GID_W-1:0];
          end
        end
        REQ_FREE: begin
          if (hit) begin
            tok_d.done = 1'b1;
            if (bit_set) begin
              bits_d[tok_i.sid_bit] = 1'b0;
              tok_d.status          = ST_OK;
            end else begin
              tok_d.status = ST_WAS_FREE;
            end
          end
        end
        REQ_LOOKUP: begin
          if (hit) begin
            tok_d.done   = 1'b1;
            tok_d.found  = bit_set;
            tok_d.status = bit_set ? ST_OK : ST_NOT_ALLOC;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_q <= '0;
      tok_q  <= '0;
    end else begin
      bits_q <= bits_d;
      tok_q  <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

// ===== hdl/sida_checker.sv =====
// Port-level checks for the session ID allocator, bound to the top level.
// Depends on sida_pkg and session_id_bitmap_allocator_assert.svh.
`include "session_id_bitmap_allocator_assert.svh"

module sida_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start,
  input logic                       busy,
  input logic [1:0]                 req_type_i,
  input logic [sida_pkg::SID_W-1:0] session_id_i,
  input logic                       done_o,
  input logic [2:0]                 status_o,
  input logic [sida_pkg::GID_W-1:0] granted_id_o,
  input logic                       found_o
);
  import sida_pkg::*;

  `SIDA_ASSERT_NEXT(a_busy_after_start, start && !busy, busy, "accepted beat did not raise busy")
  `SIDA_ASSERT(a_done_needs_busy, !done_o || $past(busy), "result strobe without a request")
  `SIDA_ASSERT(a_found_ok, !(done_o && found_o) || status_o == ST_OK, "found with bad status")
  `SIDA_ASSERT(a_fail_clean, !(done_o && status_o != ST_OK) || (granted_id_o == '0 && !found_o), "failed request carries an ID or a hit")

endmodule

bind session_id_bitmap_allocator sida_checker u_sida_checker (.*);

// ===== dv/session_id_bitmap_allocator_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for session_id_bitmap_allocator: a bitmap predictor checks every result
// beat for alloc, free, lookup and unused requests. Depends on sida_pkg and allocator RTL.
module session_id_bitmap_allocator_test;
  import sida_pkg::*;

  localparam logic [1:0] REQ_UNUSED  = 2'd3;
  localparam int         RESERVED_ID = 0;
  localparam int         CYCLE_LIMIT = 1_000_000;
  localparam int         DRAIN_CYCLES = NUM_CELLS + 4;

  typedef struct {
    status_e          status;
    logic [GID_W-1:0] gid;
    logic             found;
  } reply_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic [1:0]       req_type_i = REQ_ALLOC;
  logic [SID_W-1:0] session_id_i = '0;
  logic             done_o;
  logic [2:0]       status_o;
  logic [GID_W-1:0] granted_id_o;
  logic             found_o;

  bit [NUM_SESSIONS-1:0] held_map = '0;
  reply_t                expected_replies[$];
  int                    idle_pct = 0;
  int                    mismatches = 0;
  int                    request_count = 0;
  int                    status_tally[6] = '{default: 0};

  session_id_bitmap_allocator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_type_i  (req_type_i),
    .session_id_i(session_id_i),
    .done_o      (done_o),
    .status_o    (status_o),
    .granted_id_o(granted_id_o),
    .found_o     (found_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic reply_t resolve_request(logic [1:0] req, logic [SID_W-1:0] sid);
    reply_t r;
    int     i;
    r.status = ST_OK;
    r.gid    = '0;
    r.found  = 1'b0;
    case (req)
      REQ_ALLOC: begin
        r.status = ST_FULL;
        for (i = RESERVED_ID + 1; i < NUM_SESSIONS && r.status == ST_FULL; i++) begin
          if (!held_map[i]) begin
            held_map[i] = 1'b1;
            r.status    = ST_OK;
            r.gid       = GID_W'(i);
          end
        end
      end
      REQ_FREE: begin
        if (sid >= NUM_SESSIONS) r.status = ST_RANGE;
        else if (sid == RESERVED_ID) r.status = ST_RESERVED;
        else if (!held_map[sid]) r.status = ST_WAS_FREE;
        else held_map[sid] = 1'b0;
      end
      REQ_LOOKUP: begin
        if (sid >= NUM_SESSIONS) r.status = ST_RANGE;
        else if (held_map[sid]) r.found = 1'b1;
        else r.status = ST_NOT_ALLOC;
      end
      default: ;
    endcase
    return r;
  endfunction

  // start may drop on any cycle, busy or not; fields carry noise while it is low
  task automatic issue_request(input logic [1:0] req, input logic [SID_W-1:0] sid);
    reply_t r;
    bit     go;
    bit     accepted;
    accepted = 1'b0;
    while (!accepted) begin
      go = ($urandom_range(0, 99) >= idle_pct);
      if (go) begin
        start        <= 1'b1;
        req_type_i   <= req;
        session_id_i <= sid;
      end else begin
        start        <= 1'b0;
        req_type_i   <= 2'($urandom);
        session_id_i <= SID_W'($urandom);
      end
      @(posedge clk_i);
      accepted = go && !busy;
    end
    r = resolve_request(req, sid);
    expected_replies.push_back(r);
    request_count++;
    status_tally[r.status]++;
  endtask

  task automatic hold_until_drained();
    start <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    reply_t want;
    if (rst_ni && done_o) begin
      if (expected_replies.size() == 0) begin
        $error("unexpected result beat: status %0d granted_id %0d found %0b",
               status_o, granted_id_o, found_o);
        mismatches++;
      end else begin
        want = expected_replies.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status_o);
          mismatches++;
        end
        if (granted_id_o !== want.gid) begin
          $error("granted_id: expected %0d, actual %0d", want.gid, granted_id_o);
          mismatches++;
        end
        if (found_o !== want.found) begin
          $error("found: expected %0b, actual %0b", want.found, found_o);
          mismatches++;
        end
      end
    end
  end

  function automatic logic [SID_W-1:0] pick_session_id();
    int sel;
    int base;
    int i;
    int idx;
    sel = $urandom_range(0, 99);
    if (sel < 40) begin
      base = $urandom_range(1, NUM_SESSIONS - 1);
      for (i = 0; i < NUM_SESSIONS; i++) begin
        idx = (base + i) % NUM_SESSIONS;
        if (held_map[idx]) return SID_W'(idx);
      end
      return SID_W'(base);
    end
    if (sel < 65) return SID_W'($urandom_range(0, NUM_SESSIONS - 1));
    if (sel < 80) return SID_W'($urandom_range(0, 63));
    if (sel < 88) begin
      case ($urandom_range(0, 3))
        0: return SID_W'(RESERVED_ID);
        1: return SID_W'(NUM_SESSIONS - 1);
        2: return SID_W'(NUM_SESSIONS);
        default: return {SID_W{1'b1}};
      endcase
    end
    return SID_W'($urandom);
  endfunction

  task automatic run_random_mix(input int count, input int alloc_w, input int free_w);
    int r;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < alloc_w) issue_request(REQ_ALLOC, SID_W'($urandom));
      else if (r < alloc_w + free_w) issue_request(REQ_FREE, pick_session_id());
      else if (r < 96) issue_request(REQ_LOOKUP, pick_session_id());
      else issue_request(REQ_UNUSED, pick_session_id());
    end
  endtask

  task automatic test_directed();
    idle_pct = 0;
    issue_request(REQ_LOOKUP, SID_W'(RESERVED_ID));
    issue_request(REQ_LOOKUP, 16'd1);
    issue_request(REQ_FREE, SID_W'(RESERVED_ID));
    issue_request(REQ_FREE, 16'd1);
    issue_request(REQ_FREE, SID_W'(NUM_SESSIONS));
    issue_request(REQ_FREE, 16'hFFFF);
    issue_request(REQ_LOOKUP, SID_W'(NUM_SESSIONS));
    issue_request(REQ_LOOKUP, 16'hFFFF);
    issue_request(REQ_UNUSED, 16'hFFFF);
    issue_request(REQ_UNUSED, 16'h0000);
    issue_request(REQ_ALLOC, 16'hFFFF);
    issue_request(REQ_ALLOC, 16'h0000);
    issue_request(REQ_LOOKUP, 16'd1);
    issue_request(REQ_FREE, 16'd1);
    issue_request(REQ_LOOKUP, 16'd1);
    issue_request(REQ_ALLOC, 16'h5A5A);
    issue_request(REQ_LOOKUP, SID_W'(NUM_SESSIONS - 1));
    issue_request(REQ_FREE, SID_W'(NUM_SESSIONS - 1));
    issue_request(REQ_LOOKUP, 16'd2);
  endtask

  task automatic test_fill_to_full();
    idle_pct = 49;
    while ($countones(held_map) < NUM_SESSIONS - 1) issue_request(REQ_ALLOC, SID_W'($urandom));
    issue_request(REQ_ALLOC, 16'd0);
    issue_request(REQ_ALLOC, 16'hFFFF);
    issue_request(REQ_LOOKUP, SID_W'(NUM_SESSIONS - 1));
    issue_request(REQ_FREE, SID_W'(NUM_SESSIONS - 1));
    issue_request(REQ_FREE, SID_W'(NUM_SESSIONS / 2));
    issue_request(REQ_FREE, 16'd1);
    issue_request(REQ_LOOKUP, SID_W'(NUM_SESSIONS / 2));
    issue_request(REQ_ALLOC, 16'd0);
    issue_request(REQ_ALLOC, 16'd0);
    issue_request(REQ_ALLOC, 16'd0);
    issue_request(REQ_ALLOC, 16'd0);
  endtask

  task automatic test_random_sparse();
    idle_pct = 0;
    run_random_mix(80, 45, 25);
  endtask

  task automatic test_random_crowded();
    idle_pct = 49;
    run_random_mix(80, 35, 35);
  endtask

  task automatic test_random_churn();
    idle_pct = 38;
    run_random_mix(80, 30, 45);
  endtask

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_sparse();
    test_fill_to_full();
    test_random_crowded();
    hold_until_drained();
    test_random_churn();
    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Covered %0d requests: %0d ok, %0d table full, %0d out of range, %0d reserved,",
             request_count, status_tally[ST_OK], status_tally[ST_FULL],
             status_tally[ST_RANGE], status_tally[ST_RESERVED]);
    $display("%0d already free, %0d not allocated; %0d mismatches.",
             status_tally[ST_WAS_FREE], status_tally[ST_NOT_ALLOC], mismatches);
    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
